>>> rtl/hcni_pkg.sv
// hcni_pkg: shared types and constants of the hash-consing node interner.
// Used by hcni_ctrl, hcni_dp and hash_cons_node_interner_top; no dependencies.
package hcni_pkg;

  localparam int OP_W    = 3;
  localparam int CNT_W   = 2;
  localparam int CHILD_W = 16;
  localparam int ID_W    = 16;
  localparam int STAT_W  = 2;
  localparam int KEY_W   = OP_W + CNT_W + 3 * CHILD_W;  // 53
  localparam int HASH_W  = 64;

  localparam int IN_DATA_W  = 72;  // 69 payload bits rounded up to bytes
  localparam int OUT_DATA_W = 24;  // 18 payload bits rounded up to bytes

  localparam logic [HASH_W-1:0] HASH_GOLDEN = 64'h0000_0000_9e37_79b9;
  localparam int MIX_LEFT  = 6;
  localparam int MIX_RIGHT = 2;
  localparam int LOAD_NUM  = 7;
  localparam int LOAD_DEN  = 10;

  localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              load;       // capture request, seed hash
    logic              mix;        // one hash combine step
    logic              rd_first;   // read home slot
    logic              rd_next;    // read following slot
    logic              insert;     // write key and id at current slot
    logic              clr;        // clear one slot of the sweep
    logic              out_load;   // load output register
    logic [STAT_W-1:0] out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mix_last;    // current combine step is the final one
    logic slot_valid;  // slot just read is occupied
    logic hit;         // slot just read holds the key
    logic at_limit;    // one more entry would reach the load limit
    logic clr_done;    // sweep is at its last slot
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

>>> rtl/hcni_ram.sv
// hcni_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcni_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hcni_ctrl.sv
// hcni_ctrl: sequencer for clearing, hashing, probing and answering requests.
// Depends on hcni_pkg (cmd_t, sts_t, status codes).
module hcni_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  hcni_pkg::sts_t sts,
  output hcni_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_tready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.out_status = hcni_pkg::ST_FOUND;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mix = 1'b1;
        if (sts.mix_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_first = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.slot_valid && !sts.hit) begin
          cmd.rd_next = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          if (sts.hit) begin
            cmd.out_status = hcni_pkg::ST_FOUND;
          end else if (sts.at_limit) begin
            cmd.out_status = hcni_pkg::ST_FULL;
          end else begin
            cmd.insert     = 1'b1;
            cmd.out_status = hcni_pkg::ST_NEW;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // a request is only taken once the clearing sweep has finished
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !cmd.load || $past(sts.clr_done))
    else $error("request accepted during clearing sweep");

  // the probe always begins with a home-slot read after hashing
  a_read_after_hash: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_first |-> $past(cmd.mix) && $past(sts.mix_last))
    else $error("probe started without finished hash");

  // insert only on an empty slot
  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.slot_valid && !sts.at_limit && sts.out_free)
    else $error("insert on occupied slot or at load limit");

endmodule

>>> rtl/hcni_dp.sv
// hcni_dp: request registers, hash combine unit, slot RAM, probe pointer,
// entry counter and output register. Depends on hcni_pkg and hcni_ram.
module hcni_dp #(
  parameter int SLOT_COUNT = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hcni_pkg::cmd_t                   cmd,
  output hcni_pkg::sts_t                   sts,
  input  logic [hcni_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hcni_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int AW    = $clog2(SLOT_COUNT);
  localparam int SW    = (ID_BITS < hcni_pkg::ID_W) ? ID_BITS : hcni_pkg::ID_W;
  localparam int RW    = 1 + hcni_pkg::KEY_W + SW;
  localparam int LIMIT = (SLOT_COUNT * hcni_pkg::LOAD_NUM + hcni_pkg::LOAD_DEN - 1)
                         / hcni_pkg::LOAD_DEN;
  localparam int EW    = $clog2(SLOT_COUNT + 1);

  localparam int KO_CNT = hcni_pkg::OP_W;
  localparam int KO_C0  = KO_CNT + hcni_pkg::CNT_W;
  localparam int KO_C1  = KO_C0 + hcni_pkg::CHILD_W;
  localparam int KO_C2  = KO_C1 + hcni_pkg::CHILD_W;
  localparam int KO_NID = KO_C2 + hcni_pkg::CHILD_W;

  // request registers
  logic [hcni_pkg::KEY_W-1:0]  key;
  logic [SW-1:0]               nid;
  logic [hcni_pkg::HASH_W-1:0] hash;
  logic [hcni_pkg::CNT_W-1:0]  mix_idx;
  logic [AW-1:0]               pos;
  logic [EW-1:0]               entry_total;
  logic [AW-1:0]               clr_cnt;

  logic [hcni_pkg::CNT_W-1:0]   in_cnt;
  logic [hcni_pkg::CHILD_W-1:0] in_c0, in_c1, in_c2;
  logic [hcni_pkg::KEY_W-1:0]   key_next;

  assign in_cnt = in_tdata[KO_C0-1:KO_CNT];
  assign in_c0  = (in_cnt >= 2'd1) ? in_tdata[KO_C1-1:KO_C0] : '0;
  assign in_c1  = (in_cnt >= 2'd2) ? in_tdata[KO_C2-1:KO_C1] : '0;
  assign in_c2  = (in_cnt == 2'd3) ? in_tdata[KO_NID-1:KO_C2] : '0;
  assign key_next = {in_c2, in_c1, in_c0, in_cnt, in_tdata[KO_CNT-1:0]};

  // combine step: h ^= v + golden + (h << 6) + (h >> 2)
  logic [hcni_pkg::HASH_W-1:0]  mix_val;
  logic [hcni_pkg::HASH_W-1:0]  hash_next;
  logic [hcni_pkg::CNT_W-1:0]   key_cnt;

  assign key_cnt = key[KO_C0-1:KO_CNT];

  always_comb begin
    case (mix_idx)
      2'd0:    mix_val = hcni_pkg::HASH_W'(key_cnt);
      2'd1:    mix_val = hcni_pkg::HASH_W'(key[KO_C1-1:KO_C0]);
      2'd2:    mix_val = hcni_pkg::HASH_W'(key[KO_C2-1:KO_C1]);
      default: mix_val = hcni_pkg::HASH_W'(key[KO_NID-1:KO_C2]);
    endcase
    hash_next = hash ^ (mix_val + hcni_pkg::HASH_GOLDEN
                        + (hash << hcni_pkg::MIX_LEFT) + (hash >> hcni_pkg::MIX_RIGHT));
  end

  // slot RAM: {valid, key, id}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  assign ram_we    = cmd.clr | cmd.insert;
  assign ram_waddr = cmd.clr ? clr_cnt : pos;
  assign ram_wdata = cmd.clr ? '0 : {1'b1, key, nid};
  assign ram_re    = cmd.rd_first | cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? hash[AW-1:0] : pos + AW'(1);

  hcni_ram #(
    .WIDTH (RW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic                       q_valid;
  logic [hcni_pkg::KEY_W-1:0] q_key;
  logic [SW-1:0]              q_id;

  assign {q_valid, q_key, q_id} = ram_rdata;

  assign sts.mix_last   = (mix_idx == key_cnt);
  assign sts.slot_valid = q_valid;
  assign sts.hit        = q_valid && (q_key == key);
  assign sts.at_limit   = (entry_total >= EW'(LIMIT - 1));
  assign sts.clr_done   = &clr_cnt;
  assign sts.out_free   = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= key_next;
      nid     <= in_tdata[KO_NID+SW-1:KO_NID];
      hash    <= hcni_pkg::HASH_W'(in_tdata[KO_CNT-1:0]);
      mix_idx <= '0;
    end else if (cmd.mix) begin
      hash    <= hash_next;
      mix_idx <= mix_idx + 2'd1;
    end
    if (ram_re) begin
      pos <= ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      entry_total <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.insert) begin
        entry_total <= entry_total + EW'(1);
      end
    end
  end

  // output register
  logic [hcni_pkg::ID_W-1:0]   out_id;
  logic [hcni_pkg::STAT_W-1:0] out_status;
  logic [hcni_pkg::ID_W-1:0]   res_id;

  always_comb begin
    case (cmd.out_status)
      hcni_pkg::ST_FOUND: res_id = hcni_pkg::ID_W'(q_id);
      hcni_pkg::ST_NEW:   res_id = hcni_pkg::ID_W'(nid);
      default:            res_id = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id     <= res_id;
      out_status <= cmd.out_status;
    end
  end

  assign out_tdata = {{(hcni_pkg::OUT_DATA_W - hcni_pkg::ID_W - hcni_pkg::STAT_W){1'b0}},
                      out_status, out_id};

  // the load limit keeps an empty slot, so a probe always terminates
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total < EW'(LIMIT))
    else $error("entry count passed the load limit");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_tvalid && !out_tready) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

  // the probe pointer follows the read address by one slot per step
  a_probe_step: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_next |=> pos == $past(pos) + AW'(1))
    else $error("probe pointer did not advance");

endmodule

>>> rtl/hash_cons_node_interner_top.sv
// hash_cons_node_interner_top: top level of the expression-node interner.
// Depends on hcni_pkg, hcni_ctrl, hcni_dp (which uses hcni_ram).
//
// Hash-consing table of SLOT_COUNT slots (a power of two) with linear probing.
// After reset the block sweeps the slot RAM, one slot per cycle, with
// s_axis_tready low. A request then passes these steps from acceptance to
// result: the request is taken, n + 1 hash combine steps are made, where n is
// the number of used children, the home slot is read, and at least one slot is
// examined, one per cycle, since the single read port of the slot RAM delivers
// one slot per cycle; the result is loaded once the output register is free.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken. A miss that would bring the table
// to 70% of SLOT_COUNT returns status 2 (full) and stores nothing.
module hash_cons_node_interner_top #(
  parameter int SLOT_COUNT = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // operator_code[2:0], num_children[4:3], first_child[20:5],
  // second_child[36:21], third_child[52:37], new_id[68:53], zero pad
  input  logic [hcni_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_id[15:0], status[17:16], zero pad
  output logic [hcni_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  hcni_pkg::cmd_t cmd;
  hcni_pkg::sts_t sts;

  hcni_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcni_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (s_axis_tdata),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/hash_cons_node_interner_chk.sv
`timescale 1ns / 1ps
// hash_cons_node_interner_chk: watches both streams of the node interner, keeps its
// own copy of the hash table, predicts each binding and compares results in order.
// Depends on hcni_pkg for field widths, hash constants and status codes.
module hash_cons_node_interner_chk #(
  parameter int SLOT_COUNT = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [hcni_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [hcni_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [hcni_pkg::ID_W-1:0]   id;
    logic [hcni_pkg::STAT_W-1:0] status;
  } binding_t;

  logic [hcni_pkg::KEY_W-1:0] tab_key [SLOT_COUNT];
  logic [31:0]                tab_id  [SLOT_COUNT];
  bit                         tab_used [SLOT_COUNT];
  int unsigned                tab_entries;
  binding_t                   bindings_due [$];

  function automatic logic [hcni_pkg::HASH_W-1:0] combine(
      input logic [hcni_pkg::HASH_W-1:0] h,
      input logic [hcni_pkg::HASH_W-1:0] v);
    return h ^ (v + hcni_pkg::HASH_GOLDEN + (h << hcni_pkg::MIX_LEFT)
                + (h >> hcni_pkg::MIX_RIGHT));
  endfunction

  // Look the node up, insert it on a miss, and return the binding the block owes.
  task automatic intern_node(input logic [hcni_pkg::IN_DATA_W-1:0] req,
                             output binding_t res);
    logic [hcni_pkg::OP_W-1:0]    op;
    logic [hcni_pkg::CNT_W-1:0]   cnt;
    logic [hcni_pkg::CHILD_W-1:0] kid [3];
    logic [hcni_pkg::HASH_W-1:0]  h;
    logic [hcni_pkg::KEY_W-1:0]   key;
    logic [31:0]                  nid;
    int                           pos;
    int                           steps;
    bit                           hit;
    op  = req[hcni_pkg::OP_W-1:0];
    cnt = req[hcni_pkg::OP_W +: hcni_pkg::CNT_W];
    // unused children are neither hashed nor compared; they sit as zero in the key
    for (int i = 0; i < 3; i++)
      kid[i] = (i < cnt) ?
               req[hcni_pkg::OP_W + hcni_pkg::CNT_W + hcni_pkg::CHILD_W * i
                   +: hcni_pkg::CHILD_W] : '0;
    h = hcni_pkg::HASH_W'(op);
    h = combine(h, hcni_pkg::HASH_W'(cnt));
    for (int i = 0; i < cnt; i++)
      h = combine(h, hcni_pkg::HASH_W'(kid[i]));
    key = {kid[2], kid[1], kid[0], cnt, op};
    nid = 32'(req[hcni_pkg::OP_W + hcni_pkg::CNT_W + 3 * hcni_pkg::CHILD_W
                  +: hcni_pkg::ID_W]) & ((32'd1 << ID_BITS) - 32'd1);
    pos   = int'(h % hcni_pkg::HASH_W'(SLOT_COUNT));
    steps = 0;
    hit   = 1'b0;
    while (!hit && steps < SLOT_COUNT && tab_used[pos]) begin
      if (tab_key[pos] == key) begin
        hit = 1'b1;
      end else begin
        pos = (pos + 1) % SLOT_COUNT;
        steps++;
      end
    end
    if (hit) begin
      res = '{id: tab_id[pos][hcni_pkg::ID_W-1:0], status: hcni_pkg::ST_FOUND};
    end else if ((tab_entries + 1) * hcni_pkg::LOAD_DEN >= SLOT_COUNT * hcni_pkg::LOAD_NUM
                 || tab_used[pos]) begin
      res = '{id: '0, status: hcni_pkg::ST_FULL};
    end else begin
      tab_key[pos]  = key;
      tab_id[pos]   = nid;
      tab_used[pos] = 1'b1;
      tab_entries++;
      res = '{id: nid[hcni_pkg::ID_W-1:0], status: hcni_pkg::ST_NEW};
    end
  endtask

  always @(posedge clk) begin
    binding_t got;
    binding_t want;
    if (rst) begin
      foreach (tab_used[j]) tab_used[j] = 1'b0;
      tab_entries = 0;
      bindings_due.delete();
      fail_count = 0;
    end else begin
      // drain first: a result leaving at this edge belongs to an older request
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{id: m_axis_tdata[hcni_pkg::ID_W-1:0],
                status: m_axis_tdata[hcni_pkg::ID_W +: hcni_pkg::STAT_W]};
        if (bindings_due.size() == 0) begin
          $display("%0t: unexpected result id %h status %0d", $time, got.id, got.status);
          fail_count++;
        end else begin
          want = bindings_due.pop_front();
          if (got.id !== want.id || got.status !== want.status) begin
            $display("%0t: result mismatch: expected id %h status %0d, got id %h status %0d",
                     $time, want.id, want.status, got.id, got.status);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        intern_node(s_axis_tdata, want);
        bindings_due.insert(bindings_due.size(), want);
      end
    end
    pending = bindings_due.size();
  end

endmodule

>>> tb/hash_cons_node_interner_top_tb.sv
`timescale 1ns / 1ps
// hash_cons_node_interner_top_tb: drives node requests into the interner with random
// gaps and output stalls; the checker does prediction and comparison.
// Depends on hcni_pkg, hash_cons_node_interner_top and hash_cons_node_interner_chk.
module hash_cons_node_interner_top_tb;

  localparam int SLOT_COUNT   = 1024;
  localparam int ID_BITS      = 16;
  localparam int RANDOM_NODES = 783;
  localparam int FRESH_TARGET = 740;  // enough distinct keys to run into the load limit
  localparam int DRAIN_CYCLES = 20;
  // sweep after reset plus ~800 requests; real runs stay far below this
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [hcni_pkg::OP_W-1:0]    op;
    logic [hcni_pkg::CNT_W-1:0]   cnt;
    logic [hcni_pkg::CHILD_W-1:0] k0;
    logic [hcni_pkg::CHILD_W-1:0] k1;
    logic [hcni_pkg::CHILD_W-1:0] k2;
  } node_key_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hcni_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hcni_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int        fail_count;
  int        pending;
  int        cycles = 0;
  int        fresh_keys = 0;
  bit        send_burst = 1'b0;
  bit        take_burst = 1'b0;
  node_key_t sent_keys [$];

  always #5 clk = ~clk;

  hash_cons_node_interner_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .ID_BITS   (ID_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hash_cons_node_interner_chk #(
    .SLOT_COUNT(SLOT_COUNT),
    .ID_BITS   (ID_BITS)
  ) i_chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_node(input logic [hcni_pkg::OP_W-1:0] op,
                           input logic [hcni_pkg::CNT_W-1:0] cnt,
                           input logic [hcni_pkg::CHILD_W-1:0] k0,
                           input logic [hcni_pkg::CHILD_W-1:0] k1,
                           input logic [hcni_pkg::CHILD_W-1:0] k2,
                           input logic [hcni_pkg::ID_W-1:0] nid);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= hcni_pkg::IN_DATA_W'({nid, k2, k1, k0, cnt, op});
    do @(posedge clk); while (!(s_axis_tready && s_axis_tvalid));
    sent_keys.insert(sent_keys.size(),
                     node_key_t'{op: op, cnt: cnt, k0: k0, k1: k1, k2: k2});
  endtask

  // Mostly fresh keys until the table nears its limit, then mostly repeats,
  // which keeps hits coming while misses start to report full.
  task automatic random_node();
    node_key_t pick;
    int        r;
    int        new_pct;
    r       = $urandom_range(0, 99);
    new_pct = (fresh_keys < FRESH_TARGET) ? 97 : 45;
    pick    = '{op: hcni_pkg::OP_W'($urandom_range(0, 7)),
                cnt: hcni_pkg::CNT_W'($urandom_range(0, 3)),
                k0: hcni_pkg::CHILD_W'($urandom),
                k1: hcni_pkg::CHILD_W'($urandom),
                k2: hcni_pkg::CHILD_W'($urandom)};
    if (r >= 5 && r < new_pct) begin
      pick.cnt = hcni_pkg::CNT_W'($urandom_range(1, 3));
      fresh_keys++;
    end else if (r >= new_pct) begin
      pick = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      // children past the count must not matter for a hit
      if (pick.cnt < 1) pick.k0 = hcni_pkg::CHILD_W'($urandom);
      if (pick.cnt < 2) pick.k1 = hcni_pkg::CHILD_W'($urandom);
      if (pick.cnt < 3) pick.k2 = hcni_pkg::CHILD_W'($urandom);
    end
    send_node(pick.op, pick.cnt, pick.k0, pick.k1, pick.k2,
              hcni_pkg::ID_W'($urandom));
  endtask

  // output side: random stall before each result, with stall-free stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 50 == 0) take_burst = ($urandom_range(0, 3) == 0);
      taken++;
      stall = take_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes, key equality rules and unused-child handling
    send_node(3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_node(3'd0, 2'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_node(3'd7, 2'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_node(3'd7, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_node(3'd7, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    send_node(3'd0, 2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h1234);
    send_node(3'd0, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h2345);
    send_node(3'd1, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h3456);
    send_node(3'd2, 2'd1, 16'h1234, 16'hffff, 16'h0000, 16'h4567);
    send_node(3'd2, 2'd1, 16'h1234, 16'h0000, 16'hffff, 16'h5678);
    send_node(3'd3, 2'd2, 16'habcd, 16'h0000, 16'h0000, 16'h6789);
    send_node(3'd3, 2'd2, 16'habcd, 16'h0000, 16'hffff, 16'h789a);
    send_node(3'd3, 2'd2, 16'h0000, 16'habcd, 16'h0000, 16'h89ab);
    send_node(3'd5, 2'd3, 16'h0001, 16'h0002, 16'h0003, 16'h9abc);
    send_node(3'd5, 2'd3, 16'h0003, 16'h0002, 16'h0001, 16'habcd);
    send_node(3'd5, 2'd3, 16'h0001, 16'h0002, 16'h0003, 16'hffff);
    send_node(3'd6, 2'd2, 16'hffff, 16'h0000, 16'h5555, 16'hffff);

    for (int j = 0; j < RANDOM_NODES; j++) begin
      if (j % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      random_node();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
